// File: rtl/core/nll_pkg.sv
// ----------------------------------------------------------------------------
// nll_pkg: shared types and tables of the numeric literal lexer
// Scan state encoding, character classes, token class codes, the
// transition table and the character classifier.
// ----------------------------------------------------------------------------
package nll_pkg;

  // Default field widths
  localparam int unsigned INT_BITS_DEF  = 32;
  localparam int unsigned MANT_BITS_DEF = 64;
  localparam int unsigned FRAC_BITS_DEF = 8;
  localparam int unsigned EXP_BITS_DEF  = 16;

  // Character codes of interest
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_E_LO  = 8'h65;
  localparam logic [7:0] CH_E_UP  = 8'h45;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_USCORE = 8'h5f;

  // Scanner states, one-hot
  typedef enum logic [9:0] {
    ST_REJ   = 10'b00_0000_0001,  // rejected, held until restart
    ST_INIT  = 10'b00_0000_0010,  // token start
    ST_SIGN  = 10'b00_0000_0100,  // leading sign seen
    ST_INT   = 10'b00_0000_1000,  // integer digits
    ST_DOT   = 10'b00_0001_0000,  // dot with no digit before it
    ST_FRAC  = 10'b00_0010_0000,  // fraction
    ST_EXP   = 10'b00_0100_0000,  // e/E seen
    ST_EPOS  = 10'b00_1000_0000,  // exponent plus
    ST_ENEG  = 10'b01_0000_0000,  // exponent minus
    ST_EDIG  = 10'b10_0000_0000   // exponent digits
  } scan_state_e;

  typedef enum logic [2:0] {
    CC_OTHER  = 3'd0,
    CC_DIGIT  = 3'd1,
    CC_EXP    = 3'd2,
    CC_DOT    = 3'd3,
    CC_PLUS   = 3'd4,
    CC_MINUS  = 3'd5,
    CC_USCORE = 3'd6
  } char_class_e;

  typedef enum logic [2:0] {
    TC_INCOMPLETE = 3'd0,
    TC_INTEGER    = 3'd1,
    TC_FLOAT      = 3'd2,
    TC_FLOAT_EXP  = 3'd3,
    TC_REJECTED   = 3'd4
  } token_class_e;

  function automatic char_class_e nll_classify(logic [7:0] ch);
    char_class_e cc;
    if (ch >= CH_ZERO && ch <= CH_NINE)        cc = CC_DIGIT;
    else if (ch == CH_E_LO || ch == CH_E_UP)   cc = CC_EXP;
    else if (ch == CH_DOT)                     cc = CC_DOT;
    else if (ch == CH_PLUS)                    cc = CC_PLUS;
    else if (ch == CH_MINUS)                   cc = CC_MINUS;
    else if (ch == CH_USCORE)                  cc = CC_USCORE;
    else                                       cc = CC_OTHER;
    return cc;
  endfunction

  // Transition table; anything without an entry rejects
  function automatic scan_state_e nll_next(scan_state_e st, char_class_e cc);
    scan_state_e nx;
    nx = ST_REJ;
    case (st)
      ST_INIT: begin
        case (cc)
          CC_DIGIT:           nx = ST_INT;
          CC_DOT:             nx = ST_DOT;
          CC_PLUS, CC_MINUS:  nx = ST_SIGN;
          default:            nx = ST_REJ;
        endcase
      end
      ST_SIGN: begin
        case (cc)
          CC_DIGIT: nx = ST_INT;
          CC_DOT:   nx = ST_DOT;
          default:  nx = ST_REJ;
        endcase
      end
      ST_INT: begin
        case (cc)
          CC_DIGIT, CC_USCORE: nx = ST_INT;
          CC_EXP:              nx = ST_EXP;
          CC_DOT:              nx = ST_FRAC;
          default:             nx = ST_REJ;
        endcase
      end
      ST_DOT: begin
        case (cc)
          CC_DIGIT: nx = ST_FRAC;
          default:  nx = ST_REJ;
        endcase
      end
      ST_FRAC: begin
        case (cc)
          CC_DIGIT, CC_USCORE: nx = ST_FRAC;
          CC_EXP:              nx = ST_EXP;
          default:             nx = ST_REJ;
        endcase
      end
      ST_EXP: begin
        case (cc)
          CC_DIGIT: nx = ST_EDIG;
          CC_PLUS:  nx = ST_EPOS;
          CC_MINUS: nx = ST_ENEG;
          default:  nx = ST_REJ;
        endcase
      end
      ST_EPOS, ST_ENEG: begin
        case (cc)
          CC_DIGIT: nx = ST_EDIG;
          default:  nx = ST_REJ;
        endcase
      end
      ST_EDIG: begin
        case (cc)
          CC_DIGIT, CC_USCORE: nx = ST_EDIG;
          default:             nx = ST_REJ;
        endcase
      end
      default: nx = ST_REJ;
    endcase
    return nx;
  endfunction

  function automatic token_class_e nll_token_class(scan_state_e st);
    token_class_e tc;
    case (st)
      ST_REJ:  tc = TC_REJECTED;
      ST_INT:  tc = TC_INTEGER;
      ST_FRAC: tc = TC_FLOAT;
      ST_EDIG: tc = TC_FLOAT_EXP;
      default: tc = TC_INCOMPLETE;
    endcase
    return tc;
  endfunction

endpackage

// File: rtl/core/nll_mac10.sv
// ----------------------------------------------------------------------------
// nll_mac10: multiply-by-ten and add one decimal digit
// Shift-add form; carry_o flags a result that does not fit in W bits.
// ----------------------------------------------------------------------------
module nll_mac10 #(
  parameter int unsigned W = 32
) (
  input  logic [W-1:0] acc_i,
  input  logic [3:0]   digit_i,
  output logic [W-1:0] sum_o,
  output logic         carry_o
);

  localparam int unsigned WX = W + 4;

  logic [WX-1:0] acc_x;
  logic [WX-1:0] wide;

  // acc * 10 + d = (acc << 3) + (acc << 1) + d, never exceeds 16 * 2^W
  assign acc_x   = {4'b0000, acc_i};
  assign wide    = (acc_x << 3) + (acc_x << 1) + WX'(digit_i);
  assign sum_o   = wide[W-1:0];
  assign carry_o = |wide[WX-1:W];

endmodule

// File: rtl/core/numeric_literal_lexer_top.sv
// ----------------------------------------------------------------------------
// numeric_literal_lexer_top: character-at-a-time numeric literal scanner
//
//   channel | signals                         | dir | beat
//   --------+---------------------------------+-----+---------------------------
//   in      | in_valid_i/in_ready_o           | in  | ch_i, start_req_i
//   out     | out_valid_o/out_ready_i         | out | token class and values
//
// One beat per cycle while the output is not stalled; a character is captured in
// the input register, then its result in the state registers that drive the output.
// The cycle is set by one pass from the input register: restart clear, table step
// and three parallel multiply-by-ten adders (widest MantBits); mantissa and exponent saturate.
// Reset puts the scanner in the token start state with all values cleared.
// A stalled output holds the state registers; the input register still takes
// one more beat, then in_ready_o drops.
// ----------------------------------------------------------------------------
module numeric_literal_lexer_top #(
  parameter int unsigned IntBits  = nll_pkg::INT_BITS_DEF,
  parameter int unsigned MantBits = nll_pkg::MANT_BITS_DEF,
  parameter int unsigned FracBits = nll_pkg::FRAC_BITS_DEF,
  parameter int unsigned ExpBits  = nll_pkg::EXP_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          ch_i,
  input  logic                start_req_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [2:0]          token_class_o,
  output logic                mant_negative_o,
  output logic [IntBits-1:0]  int_value_o,
  output logic                int_overflow_o,
  output logic [MantBits-1:0] dec_mantissa_o,
  output logic [FracBits-1:0] frac_digits_o,
  output logic                exp_negative_o,
  output logic [ExpBits-1:0]  exp_value_o
);

  import nll_pkg::*;

  // Input register
  logic       in_vld_q;
  logic [7:0] ch_q;
  logic       start_q;
  logic       out_vld_q;
  logic       advance;
  logic       fire;

  assign advance    = !out_vld_q || out_ready_i;
  assign fire       = in_vld_q && advance;
  assign in_ready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_vld_q <= 1'b1;
    end else if (fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      ch_q    <= ch_i;
      start_q <= start_req_i;
    end
  end

  // Scanner state, doubling as the result register
  scan_state_e         st_q, st_d, st_cur;
  logic                neg_q, neg_d, neg_cur;
  logic [IntBits-1:0]  int_q, int_d, int_cur;
  logic                ovf_q, ovf_d, ovf_cur;
  logic [MantBits-1:0] dec_q, dec_d, dec_cur;
  logic [FracBits-1:0] frac_q, frac_d, frac_cur;
  logic                eneg_q, eneg_d, eneg_cur;
  logic [ExpBits-1:0]  exp_q, exp_d, exp_cur;

  // Restart clears everything before the character is consumed
  assign st_cur   = start_q ? ST_INIT : st_q;
  assign neg_cur  = start_q ? 1'b0 : neg_q;
  assign int_cur  = start_q ? '0 : int_q;
  assign ovf_cur  = start_q ? 1'b0 : ovf_q;
  assign dec_cur  = start_q ? '0 : dec_q;
  assign frac_cur = start_q ? '0 : frac_q;
  assign eneg_cur = start_q ? 1'b0 : eneg_q;
  assign exp_cur  = start_q ? '0 : exp_q;

  char_class_e cls;
  scan_state_e nxt;
  logic        is_digit;
  logic [3:0]  digit;

  assign cls      = nll_classify(ch_q);
  assign nxt      = nll_next(st_cur, cls);
  assign is_digit = (cls == CC_DIGIT);
  assign digit    = is_digit ? ch_q[3:0] : 4'd0;

  // Digit accumulators
  logic [IntBits-1:0]  int_sum;
  logic                int_carry;
  logic [MantBits-1:0] dec_sum;
  logic                dec_carry;
  logic [ExpBits-1:0]  exp_sum;
  logic                exp_carry;

  nll_mac10 #(.W(IntBits)) u_int_mac (
    .acc_i   (int_cur),
    .digit_i (digit),
    .sum_o   (int_sum),
    .carry_o (int_carry)
  );

  nll_mac10 #(.W(MantBits)) u_dec_mac (
    .acc_i   (dec_cur),
    .digit_i (digit),
    .sum_o   (dec_sum),
    .carry_o (dec_carry)
  );

  nll_mac10 #(.W(ExpBits)) u_exp_mac (
    .acc_i   (exp_cur),
    .digit_i (digit),
    .sum_o   (exp_sum),
    .carry_o (exp_carry)
  );

  // Update the accumulator that the entered state owns
  always_comb begin
    st_d   = nxt;
    neg_d  = neg_cur;
    int_d  = int_cur;
    ovf_d  = ovf_cur;
    dec_d  = dec_cur;
    frac_d = frac_cur;
    eneg_d = eneg_cur;
    exp_d  = exp_cur;
    case (nxt)
      ST_SIGN: begin
        if (cls == CC_MINUS) neg_d = 1'b1;
      end
      ST_INT: begin
        if (is_digit) begin
          int_d = int_sum;
          ovf_d = ovf_cur || int_carry;
          dec_d = dec_carry ? '1 : dec_sum;
        end
      end
      ST_FRAC: begin
        // the dot that ends the integer part adds no digit
        if (st_cur != ST_INT && is_digit) begin
          dec_d = dec_carry ? '1 : dec_sum;
          if (frac_cur != '1) frac_d = frac_cur + 1'b1;
        end
      end
      ST_EXP: begin
        exp_d  = '0;
        eneg_d = 1'b0;
      end
      ST_ENEG: begin
        eneg_d = 1'b1;
      end
      ST_EDIG: begin
        if (is_digit) exp_d = exp_carry ? '1 : exp_sum;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_INIT;
      neg_q  <= 1'b0;
      int_q  <= '0;
      ovf_q  <= 1'b0;
      dec_q  <= '0;
      frac_q <= '0;
      eneg_q <= 1'b0;
      exp_q  <= '0;
    end else if (fire) begin
      st_q   <= st_d;
      neg_q  <= neg_d;
      int_q  <= int_d;
      ovf_q  <= ovf_d;
      dec_q  <= dec_d;
      frac_q <= frac_d;
      eneg_q <= eneg_d;
      exp_q  <= exp_d;
    end
  end

  // Output beat valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign token_class_o   = nll_token_class(st_q);
  assign mant_negative_o = neg_q;
  assign int_value_o     = int_q;
  assign int_overflow_o  = ovf_q;
  assign dec_mantissa_o  = dec_q;
  assign frac_digits_o   = frac_q;
  assign exp_negative_o  = eneg_q;
  assign exp_value_o     = exp_q;

endmodule
